// ===== rtl/core/ssd_pkg.sv =====
package ssd_pkg;

  localparam int WINDOW     = 16;
  localparam int CNT_W      = $clog2(WINDOW);
  localparam int ADC_BITS   = 12;
  localparam int RATIO_W    = 16;
  localparam int FRAC_BITS  = 8;
  localparam int VOLT_W     = 20;
  localparam int SUM_W      = VOLT_W + CNT_W;
  localparam int PROD_W     = ADC_BITS + RATIO_W;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 20;

  localparam logic [CFG_IDX_W-1:0] REG_DIVIDER_RATIO       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DIVIDER_RATIO_CHECK = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_VOLTAGE         = 2'd2;

  localparam logic [RATIO_W-1:0] RATIO_RESET = 16'd256;

  localparam logic [1:0] ST_COLLECTING = 2'd0;
  localparam logic [1:0] ST_WINDOW     = 2'd1;
  localparam logic [1:0] ST_DONE       = 2'd2;
  localparam logic [1:0] ST_ABORTED    = 2'd3;

  localparam logic [1:0] RS_BELOW_RISING  = 2'd0;
  localparam logic [1:0] RS_BELOW_FLAT    = 2'd1;
  localparam logic [1:0] RS_STABILIZING   = 2'd2;

  typedef struct packed {
    logic [1:0]        status;
    logic              bypass_on;
    logic [VOLT_W-1:0] window_average;
    logic [1:0]        waiting_reason;
  } result_t;

endpackage

// ===== rtl/core/ssd_if.sv =====
interface ssd_sample_if import ssd_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [ADC_BITS-1:0] adc_sample;

  modport source (output valid, output adc_sample, input ready);
  modport sink (input valid, input adc_sample, output ready);
endinterface

interface ssd_result_if import ssd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        status;
  logic              bypass_on;
  logic [VOLT_W-1:0] window_average;
  logic [1:0]        waiting_reason;

  modport source (output valid, output status, output bypass_on, output window_average,
                  output waiting_reason, input ready);
  modport sink (input valid, input status, input bypass_on, input window_average,
                input waiting_reason, output ready);
endinterface

interface ssd_cfg_if import ssd_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/ssd_settle.sv =====
module ssd_settle import ssd_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic [VOLT_W-1:0] scaled,
  input  logic              ratio_ok,
  input  logic [VOLT_W-1:0] min_voltage,
  output result_t           result
);

  typedef enum logic [1:0] {
    PH_RUNNING,
    PH_DONE,
    PH_ABORTED
  } phase_t;

  phase_t            phase;
  phase_t            phase_next;
  logic [SUM_W-1:0]  window_sum;
  logic [SUM_W-1:0]  window_sum_next;
  logic [CNT_W-1:0]  sample_count;
  logic [CNT_W-1:0]  sample_count_next;
  logic [VOLT_W-1:0] previous_average;
  logic [VOLT_W-1:0] previous_average_next;
  logic [VOLT_W-1:0] final_average;
  logic [VOLT_W-1:0] final_average_next;
  logic [1:0]        last_reason;
  logic [1:0]        last_reason_next;
  logic [SUM_W-1:0]  sum_added;
  logic [VOLT_W-1:0] average;
  logic              reached;
  logic              stopped;

  assign sum_added = window_sum + SUM_W'(scaled);
  assign average   = VOLT_W'(sum_added / SUM_W'(WINDOW));
  assign reached   = average >= min_voltage;
  assign stopped   = average <= previous_average;

  always_comb begin
    phase_next            = phase;
    window_sum_next       = window_sum;
    sample_count_next     = sample_count;
    previous_average_next = previous_average;
    final_average_next    = final_average;
    last_reason_next      = last_reason;
    result                = '{ST_ABORTED, 1'b0, previous_average, RS_BELOW_RISING};
    case (phase)
      PH_DONE: begin
        result = '{ST_DONE, 1'b1, final_average, RS_BELOW_RISING};
      end
      PH_RUNNING: begin
        if (!ratio_ok) begin
          phase_next = PH_ABORTED;
        end else if (sample_count != CNT_W'(WINDOW - 1)) begin
          window_sum_next   = sum_added;
          sample_count_next = sample_count + CNT_W'(1);
          result = '{ST_COLLECTING, 1'b0, previous_average, last_reason};
        end else begin
          window_sum_next       = '0;
          sample_count_next     = '0;
          previous_average_next = average;
          if (reached && stopped) begin
            phase_next         = PH_DONE;
            final_average_next = average;
            result = '{ST_DONE, 1'b1, average, RS_BELOW_RISING};
          end else begin
            last_reason_next = reached ? RS_STABILIZING :
                               (stopped ? RS_BELOW_FLAT : RS_BELOW_RISING);
            result = '{ST_WINDOW, 1'b0, average, last_reason_next};
          end
        end
      end
      default: begin
        result = '{ST_ABORTED, 1'b0, previous_average, RS_BELOW_RISING};
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_RUNNING;
      window_sum       <= '0;
      sample_count     <= '0;
      previous_average <= '0;
      final_average    <= '0;
      last_reason      <= RS_BELOW_RISING;
    end else if (step) begin
      phase            <= phase_next;
      window_sum       <= window_sum_next;
      sample_count     <= sample_count_next;
      previous_average <= previous_average_next;
      final_average    <= final_average_next;
      last_reason      <= last_reason_next;
    end
  end

endmodule

// ===== rtl/core/soft_start_settle_detector_top.sv =====
// Soft-start settle detector. Each sample request carries one ADC code and yields exactly one
// result request. A sample is taken every cycle while the result side keeps up; an accepted
// sample is first held in the multiply register, and the window accumulate and decide logic
// then loads its result into the result register. When the result side stalls, one further
// sample is still taken into the multiply register before the sample side is held.
// Configuration writes are taken every cycle and should be made while no sample is in flight.
module soft_start_settle_detector_top import ssd_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  ssd_sample_if.sink    sample,
  ssd_result_if.source  result,
  ssd_cfg_if.sink       cfg
);

  logic [RATIO_W-1:0] divider_ratio;
  logic [RATIO_W-1:0] divider_ratio_check;
  logic [VOLT_W-1:0]  min_voltage;
  logic               s1_valid;
  logic [VOLT_W-1:0]  s1_scaled;
  logic [PROD_W-1:0]  product;
  logic               advance;
  logic               step;
  result_t            settle_result;
  logic               out_valid;
  result_t            out_data;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      divider_ratio       <= RATIO_RESET;
      divider_ratio_check <= RATIO_RESET;
      min_voltage         <= '0;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_DIVIDER_RATIO:       divider_ratio       <= cfg.data[RATIO_W-1:0];
        REG_DIVIDER_RATIO_CHECK: divider_ratio_check <= cfg.data[RATIO_W-1:0];
        REG_MIN_VOLTAGE:         min_voltage         <= cfg.data[VOLT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign advance      = !out_valid || result.ready;
  assign step         = advance && s1_valid;
  assign sample.ready = !s1_valid || advance;
  assign product      = PROD_W'(sample.adc_sample) * PROD_W'(divider_ratio);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (sample.ready) begin
      s1_valid <= sample.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sample.valid && sample.ready) begin
      s1_scaled <= VOLT_W'(product >> FRAC_BITS);
    end
  end

  ssd_settle u_settle (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .scaled      (s1_scaled),
    .ratio_ok    (divider_ratio == divider_ratio_check),
    .min_voltage (min_voltage),
    .result      (settle_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_data <= settle_result;
    end
  end

  assign result.valid          = out_valid;
  assign result.status         = out_data.status;
  assign result.bypass_on      = out_data.bypass_on;
  assign result.window_average = out_data.window_average;
  assign result.waiting_reason = out_data.waiting_reason;

  a_bypass_done : assert property (@(posedge clk) disable iff (rst)
    result.valid |-> (result.bypass_on == (result.status == ST_DONE)))
    else $error("bypass drive disagrees with status");

  a_latched_reason : assert property (@(posedge clk) disable iff (rst)
    result.valid && (result.status == ST_DONE || result.status == ST_ABORTED)
      |-> result.waiting_reason == RS_BELOW_RISING)
    else $error("waiting reason set while latched");

  a_step_delivers : assert property (@(posedge clk) disable iff (rst)
    step |=> result.valid)
    else $error("processed sample produced no result");

  a_stall_holds : assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.ready && s1_valid |-> !sample.ready)
    else $error("sample taken with both stages full");

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 100ps

module tb;
  import ssd_pkg::*;

  typedef enum logic [1:0] {PH_RUNNING, PH_SETTLED, PH_ABORTED} settle_phase_e;
  typedef enum logic [1:0] {RX_ALWAYS, RX_RANDOM, RX_PATTERN, RX_RARE} rx_mode_e;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam logic [ADC_BITS-1:0]  ADC_MAX    = {ADC_BITS{1'b1}};
  localparam logic [VOLT_W-1:0]    VOLT_MAX   = {VOLT_W{1'b1}};

  logic clk = 1'b0;
  logic rst;

  ssd_sample_if sample_bus ();
  ssd_result_if result_bus ();
  ssd_cfg_if    cfg_bus ();

  soft_start_settle_detector_top u_dut (
    .clk    (clk),
    .rst    (rst),
    .sample (sample_bus),
    .result (result_bus),
    .cfg    (cfg_bus)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Predicted register and detector state.
  logic [RATIO_W-1:0] ratio_q;
  logic [RATIO_W-1:0] ratio_check_q;
  logic [VOLT_W-1:0]  min_volt_q;
  logic [SUM_W-1:0]   acc_sum;
  int unsigned        acc_count;
  logic [VOLT_W-1:0]  last_avg;
  logic [VOLT_W-1:0]  held_avg;
  logic [1:0]         last_why;
  settle_phase_e      settle_phase;

  result_t     awaited_results[$];
  int unsigned fail_count;
  int unsigned samples_sent;
  int unsigned results_seen;
  int unsigned windows_by_reason[3];

  int unsigned burst_left;
  bit          steady_sender;
  rx_mode_e    rx_mode;
  int unsigned hold_request;
  int unsigned hold_left;
  logic [7:0]  rx_pattern;

  task reset_predictor();
    ratio_q       = RATIO_RESET;
    ratio_check_q = RATIO_RESET;
    min_volt_q    = '0;
    acc_sum       = '0;
    acc_count     = 0;
    last_avg      = '0;
    held_avg      = '0;
    last_why      = RS_BELOW_RISING;
    settle_phase  = PH_RUNNING;
  endtask

  task apply_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    case (idx)
      REG_DIVIDER_RATIO: begin
        ratio_q = value[RATIO_W-1:0];
      end
      REG_DIVIDER_RATIO_CHECK: begin
        ratio_check_q = value[RATIO_W-1:0];
      end
      REG_MIN_VOLTAGE: begin
        min_volt_q = value[VOLT_W-1:0];
      end
      default: begin
      end
    endcase
  endtask

  task predict_settle_result(input logic [ADC_BITS-1:0] code, output result_t r);
    logic [PROD_W-1:0] prod;
    logic [VOLT_W-1:0] scaled;
    logic [VOLT_W-1:0] avg;
    logic              reached;
    logic              stopped;
    if (settle_phase == PH_SETTLED) begin
      r = {ST_DONE, 1'b1, held_avg, RS_BELOW_RISING};
    end else if (settle_phase == PH_ABORTED || ratio_q != ratio_check_q) begin
      settle_phase = PH_ABORTED;
      r = {ST_ABORTED, 1'b0, last_avg, RS_BELOW_RISING};
    end else begin
      prod      = PROD_W'(code) * PROD_W'(ratio_q);
      scaled    = VOLT_W'(prod >> FRAC_BITS);
      acc_sum   = acc_sum + SUM_W'(scaled);
      acc_count = acc_count + 1;
      if (acc_count < WINDOW) begin
        r = {ST_COLLECTING, 1'b0, last_avg, last_why};
      end else begin
        avg       = VOLT_W'(acc_sum / WINDOW);
        acc_sum   = '0;
        acc_count = 0;
        reached   = avg >= min_volt_q;
        stopped   = avg <= last_avg;
        last_avg  = avg;
        if (reached && stopped) begin
          settle_phase = PH_SETTLED;
          held_avg     = avg;
          r = {ST_DONE, 1'b1, avg, RS_BELOW_RISING};
        end else begin
          last_why = reached ? RS_STABILIZING : (stopped ? RS_BELOW_FLAT : RS_BELOW_RISING);
          windows_by_reason[last_why]++;
          r = {ST_WINDOW, 1'b0, avg, last_why};
        end
      end
    end
  endtask

  task write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= value;
    do @(posedge clk); while (!cfg_bus.ready);
    apply_reg(idx, value);
  endtask

  task configure(input logic [CFG_DATA_W-1:0] ratio_data, input logic [CFG_DATA_W-1:0] check_data,
                 input logic [CFG_DATA_W-1:0] min_data);
    write_reg(REG_DIVIDER_RATIO, ratio_data);
    write_reg(REG_DIVIDER_RATIO_CHECK, check_data);
    write_reg(REG_MIN_VOLTAGE, min_data);
    if ($urandom_range(2, 0) == 0) begin
      write_reg(REG_UNUSED, CFG_DATA_W'($urandom));
    end
    cfg_bus.valid <= 1'b0;
  endtask

  task send_sample(input logic [ADC_BITS-1:0] code);
    int unsigned gap;
    result_t     r;
    if (burst_left == 0) begin
      burst_left = $urandom_range(24, 1);
      gap = steady_sender ? 0 : $urandom_range(6, 0);
      if (gap != 0) begin
        sample_bus.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    sample_bus.valid      <= 1'b1;
    sample_bus.adc_sample <= code;
    do @(posedge clk); while (!sample_bus.ready);
    predict_settle_result(code, r);
    awaited_results.push_back(r);
    samples_sent++;
  endtask

  task wait_drained();
    sample_bus.valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
  endtask

  // Each run of WINDOW samples gets one flavor so flat, rising and falling averages all occur.
  task send_mixed_samples(input int unsigned count);
    int unsigned         flavor;
    logic [ADC_BITS-1:0] level;
    logic [ADC_BITS-1:0] code;
    for (int unsigned i = 0; i < count; i++) begin
      if (i % WINDOW == 0) begin
        flavor = $urandom_range(4, 0);
        level  = ADC_BITS'($urandom);
      end
      case (flavor)
        0: code = ADC_BITS'($urandom);
        1: code = level;
        2: code = $urandom_range(1, 0) ? ADC_MAX : '0;
        3: code = ADC_BITS'($urandom_range(15, 0));
        default: code = ADC_MAX - ADC_BITS'($urandom_range(63, 0));
      endcase
      send_sample(code);
    end
  endtask

  task check_result();
    result_t got;
    result_t want;
    got = {result_bus.status, result_bus.bypass_on, result_bus.window_average,
           result_bus.waiting_reason};
    results_seen++;
    if (awaited_results.size() == 0) begin
      fail_count++;
      if (fail_count <= 10) begin
        $display("%0t: result with nothing awaited: status %0d bypass %0d avg %0d reason %0d",
                 $realtime, got.status, got.bypass_on, got.window_average, got.waiting_reason);
      end
    end else begin
      want = awaited_results.pop_front();
      if (got.status !== want.status || got.bypass_on !== want.bypass_on ||
          got.window_average !== want.window_average ||
          got.waiting_reason !== want.waiting_reason) begin
        fail_count++;
        if (fail_count <= 10) begin
          $display("%0t: result %0d expected status %0d bypass %0d avg %0d reason %0d",
                   $realtime, results_seen, want.status, want.bypass_on, want.window_average,
                   want.waiting_reason);
          $display("%0t: result %0d got      status %0d bypass %0d avg %0d reason %0d",
                   $realtime, results_seen, got.status, got.bypass_on, got.window_average,
                   got.waiting_reason);
        end
      end
    end
  endtask

  initial begin
    result_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && result_bus.valid && result_bus.ready) begin
        check_result();
      end
      if (hold_request != 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left != 0) begin
        hold_left--;
        result_bus.ready <= 1'b0;
      end else begin
        case (rx_mode)
          RX_ALWAYS: result_bus.ready <= 1'b1;
          RX_RANDOM: result_bus.ready <= $urandom_range(99, 0) < 60;
          RX_PATTERN: begin
            result_bus.ready <= rx_pattern[0];
            rx_pattern = {rx_pattern[0], rx_pattern[7:1]};
          end
          default: result_bus.ready <= $urandom_range(99, 0) < 15;
        endcase
      end
    end
  end

  task test_directed_extremes();
    rx_mode       = RX_ALWAYS;
    steady_sender = 1'b1;
    // Full-scale ratio with the minimum out of reach: first window rises from zero.
    configure(20'h0FFFF, 20'h0FFFF, VOLT_MAX);
    send_sample('0);
    repeat (WINDOW - 1) send_sample(ADC_MAX);
    wait_drained();
    // A zero ratio flattens every sample, so the average falls.
    configure(20'h00000, 20'h00000, VOLT_MAX);
    for (int i = 0; i < WINDOW; i++) send_sample(i[0] ? ADC_MAX : '0);
    wait_drained();
    configure(20'h00001, 20'h00001, VOLT_MAX);
    repeat (WINDOW) send_sample(ADC_MAX);
    wait_drained();
  endtask

  task test_reached_rising();
    rx_mode       = RX_PATTERN;
    steady_sender = 1'b0;
    configure(20'h00100, 20'h00100, 20'd100);
    repeat (WINDOW) send_sample(12'd100);
    repeat (WINDOW) send_sample(12'd200);
    repeat (WINDOW) send_sample(ADC_MAX);
    wait_drained();
  endtask

  task test_random_windows();
    logic [RATIO_W-1:0] ratio;
    logic [31:0]        top_avg;
    logic [VOLT_W-1:0]  min_v;
    for (int phase_idx = 0; phase_idx < 12; phase_idx++) begin
      case ($urandom_range(5, 0))
        0: ratio = '0;
        1: ratio = '1;
        default: ratio = RATIO_W'($urandom);
      endcase
      // Keep the minimum above the largest reachable average so the detector stays running.
      top_avg = (32'(ADC_MAX) * 32'(ratio)) >> FRAC_BITS;
      min_v = ($urandom_range(3, 0) == 0) ? VOLT_MAX
                                          : VOLT_W'($urandom_range(VOLT_MAX, top_avg + 1));
      configure({4'($urandom), ratio}, {4'($urandom), ratio}, min_v);
      rx_mode       = rx_mode_e'($urandom_range(3, 0) == 3 ? $urandom_range(3, 0)
                                                         : $urandom_range(2, 0));
      steady_sender = $urandom_range(3, 0) == 0;
      rx_pattern    = 8'($urandom) | 8'h01;
      send_mixed_samples(100);
      wait_drained();
    end
  endtask

  task test_backpressure();
    configure(20'(RATIO_W'($urandom)), 20'(ratio_q), VOLT_MAX);
    configure(20'(ratio_q), 20'(ratio_q), VOLT_MAX);
    rx_mode       = RX_ALWAYS;
    steady_sender = 1'b1;
    send_mixed_samples(10);
    hold_request = 150;
    send_mixed_samples(30);
    wait_drained();
    rx_mode = RX_RARE;
    send_mixed_samples(30);
    wait_drained();
  endtask

  task test_settle_and_hold();
    logic [ADC_BITS-1:0] level;
    int unsigned         guard;
    level = ADC_BITS'($urandom_range(ADC_MAX, 1));
    rx_mode       = RX_RANDOM;
    steady_sender = 1'b0;
    // Unit ratio makes the average equal the level, so the minimum is met exactly.
    configure(20'h00100, 20'h00100, 20'(level));
    guard = 0;
    while (settle_phase != PH_SETTLED && guard < 5 * WINDOW) begin
      send_sample(level);
      guard++;
    end
    send_mixed_samples(20);
    wait_drained();
    // Once settled, a ratio mismatch and a new minimum leave the latched result alone.
    configure(20'h01234, 20'h00100, VOLT_W'($urandom));
    send_mixed_samples(20);
    wait_drained();
  endtask

  initial begin
    rst                   <= 1'b1;
    sample_bus.valid      <= 1'b0;
    sample_bus.adc_sample <= '0;
    cfg_bus.valid         <= 1'b0;
    cfg_bus.index         <= '0;
    cfg_bus.data          <= '0;
    reset_predictor();
    fail_count    = 0;
    samples_sent  = 0;
    results_seen  = 0;
    burst_left    = 0;
    steady_sender = 1'b1;
    rx_mode       = RX_ALWAYS;
    rx_pattern    = 8'b1011_0111;
    hold_request  = 0;
    hold_left     = 0;
    foreach (windows_by_reason[i]) windows_by_reason[i] = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    test_directed_extremes();
    test_reached_rising();
    test_random_windows();
    test_backpressure();
    test_settle_and_hold();

    wait_drained();
    repeat (10) @(posedge clk);
    $display("Sent %0d samples and checked %0d results under varied stalls.", samples_sent,
             results_seen);
    $display("Windows rising %0d, flat %0d, stabilizing %0d; settled at average %0d.",
             windows_by_reason[RS_BELOW_RISING], windows_by_reason[RS_BELOW_FLAT],
             windows_by_reason[RS_STABILIZING], held_avg);
    if (fail_count == 0 && awaited_results.size() == 0) begin
      $display("[soft_start_settle_detector_top] OK");
    end else begin
      $display("[soft_start_settle_detector_top] ERROR");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("[soft_start_settle_detector_top] ERROR");
    $finish;
  end

endmodule
